// ===== rtl/core/u8u16_pkg.sv =====
package u8u16_pkg;

  // code point and unit widths
  localparam int CpWidth   = 31;
  localparam int UnitWidth = 16;
  localparam int ByteWidth = 8;

  // default depth of the code point queue
  localparam int QueueDepth = 4;

  // lead byte classes by count of leading ones
  localparam logic [2:0] OnesAscii    = 3'd0;
  localparam logic [2:0] OnesLone     = 3'd1;
  localparam logic [2:0] OnesBadLead  = 3'd7;
  localparam logic [2:0] BadRunLength = 3'd6;

  // surrogate constants
  localparam logic [CpWidth-1:0]   SuppBase  = 31'h0001_0000;
  localparam logic [UnitWidth-1:0] HighSurr  = 16'hD800;
  localparam logic [5:0]           LowPrefix = 6'b110111;

  // one decoded code point waiting for the back end
  typedef struct packed {
    logic               pair;
    logic [CpWidth-1:0] cp;
  } cp_item_t;

endpackage

// ===== rtl/core/u8u16_front.sv =====
module u8u16_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [7:0]              in_byte,
  input  logic                    q_full,
  output logic                    q_push,
  output u8u16_pkg::cp_item_t     q_item
);
  import u8u16_pkg::*;

  logic [2:0]         bytes_left, bytes_left_next;
  logic [CpWidth-1:0] code_accum, code_accum_next;
  logic               bad_lead_run, bad_lead_run_next;

  logic               accept;
  logic [2:0]         lead_ones;
  logic [7:0]         lead_bits;
  logic [CpWidth-1:0] accum_shift;
  logic               emit;
  logic [CpWidth-1:0] emit_cp;

  assign accept = push & ~q_full;

  // count leading ones of a lead byte, bit 0 never checked
  always_comb begin
    priority casez (in_byte)
      8'b1111_111?: lead_ones = 3'd7;
      8'b1111_110?: lead_ones = 3'd6;
      8'b1111_10??: lead_ones = 3'd5;
      8'b1111_0???: lead_ones = 3'd4;
      8'b1110_????: lead_ones = 3'd3;
      8'b110?_????: lead_ones = 3'd2;
      8'b10??_????: lead_ones = 3'd1;
      default:      lead_ones = 3'd0;
    endcase
  end

  // payload bits of the lead byte and the shifted accumulator
  assign lead_bits   = in_byte & (8'hFF >> lead_ones);
  assign accum_shift = {code_accum[CpWidth-7:0], in_byte[5:0]};

  // decoder state update
  always_comb begin
    bytes_left_next   = bytes_left;
    code_accum_next   = code_accum;
    bad_lead_run_next = bad_lead_run;
    emit              = 1'b0;
    emit_cp           = '0;
    if (accept) begin
      if (in_byte == 8'd0) begin
        bytes_left_next   = '0;
        code_accum_next   = '0;
        bad_lead_run_next = 1'b0;
      end else if (bytes_left != 3'd0) begin
        bytes_left_next = bytes_left - 3'd1;
        if (!bad_lead_run) begin
          code_accum_next = accum_shift;
        end
        if (bytes_left == 3'd1) begin
          emit              = 1'b1;
          emit_cp           = bad_lead_run ? '0 : accum_shift;
          code_accum_next   = '0;
          bad_lead_run_next = 1'b0;
        end
      end else if (lead_ones == OnesBadLead) begin
        bad_lead_run_next = 1'b1;
        code_accum_next   = '0;
        bytes_left_next   = BadRunLength;
      end else if (lead_ones == OnesAscii || lead_ones == OnesLone) begin
        emit            = 1'b1;
        emit_cp         = {{(CpWidth-8){1'b0}}, lead_bits};
        code_accum_next = '0;
      end else begin
        code_accum_next   = {{(CpWidth-8){1'b0}}, lead_bits};
        bad_lead_run_next = 1'b0;
        bytes_left_next   = lead_ones - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left   <= '0;
      code_accum   <= '0;
      bad_lead_run <= 1'b0;
    end else begin
      bytes_left   <= bytes_left_next;
      code_accum   <= code_accum_next;
      bad_lead_run <= bad_lead_run_next;
    end
  end

  // classify finished code point for the back end
  assign q_push       = emit;
  assign q_item.cp    = emit_cp;
  assign q_item.pair  = |emit_cp[CpWidth-1:UnitWidth];

endmodule

// ===== rtl/core/u8u16_queue.sv =====
module u8u16_queue #(
  parameter int DEPTH = u8u16_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  u8u16_pkg::cp_item_t wr_item,
  input  logic                rd_en,
  output u8u16_pkg::cp_item_t rd_item,
  output logic                full,
  output logic                empty
);
  import u8u16_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  cp_item_t        entries [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr, do_rd;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_item = entries[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/u8u16_back.sv =====
module u8u16_back (
  input  logic                clk,
  input  logic                rst,
  input  u8u16_pkg::cp_item_t head,
  input  logic                head_empty,
  input  logic                pop,
  output logic                head_pop,
  output logic [15:0]         code_unit,
  output logic                last_unit
);
  import u8u16_pkg::*;

  logic               low_half;
  logic [CpWidth-1:0] supp_off;
  logic               word_taken;

  // surrogate offset above the basic plane
  assign supp_off = head.cp - SuppBase;

  // unit shown for the head code point
  always_comb begin
    if (!head.pair) begin
      code_unit = head.cp[UnitWidth-1:0];
      last_unit = 1'b1;
    end else if (!low_half) begin
      code_unit = supp_off[UnitWidth+9:10] | HighSurr;
      last_unit = 1'b0;
    end else begin
      code_unit = {LowPrefix, head.cp[9:0]};
      last_unit = 1'b1;
    end
  end

  assign word_taken = pop & ~head_empty;
  assign head_pop   = word_taken & last_unit;

  // half tracker for surrogate pairs
  always_ff @(posedge clk) begin
    if (rst) begin
      low_half <= 1'b0;
    end else if (word_taken) begin
      low_half <= ~last_unit;
    end
  end

endmodule

// ===== rtl/core/utf8_to_utf16_converter.sv =====
// channel   | handshake         | payload
// input     | push / full       | in_byte[7:0]
// result    | pop / empty       | code_unit[15:0], last_unit
//
// one byte is accepted per cycle while the code point queue has room.
// a code point above 0xFFFF leaves as two words over two pops, but it takes
// at least four bytes, so the result side keeps pace with one byte per cycle.
// a decoded code point is registered in the code point queue before its result words show.
// rst is synchronous and clears decoder state, queue and pair tracker.
// stalls on the result side fill the queue, then full rises.
module utf8_to_utf16_converter #(
  parameter int QUEUE_DEPTH = u8u16_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic [7:0]  in_byte,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic        last_unit
);
  import u8u16_pkg::*;

  logic     q_push;
  cp_item_t q_item;
  cp_item_t head;
  logic     head_pop;

  // byte decoder
  u8u16_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .in_byte (in_byte),
    .q_full  (full),
    .q_push  (q_push),
    .q_item  (q_item)
  );

  // code point queue
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_item),
    .rd_en   (head_pop),
    .rd_item (head),
    .full    (full),
    .empty   (empty)
  );

  // unit emitter
  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (empty),
    .pop        (pop),
    .head_pop   (head_pop),
    .code_unit  (code_unit),
    .last_unit  (last_unit)
  );

  // high surrogate taken, low surrogate must follow
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last_unit) |=> (!empty && last_unit))
    else $error("low surrogate missing after high surrogate");

  // a zero byte never yields a code point
  a_zero_silent: assert property (@(posedge clk) disable iff (rst)
    (push && !full && in_byte == 8'd0) |-> !q_push)
    else $error("zero byte produced a code point");

  // queue empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("queue not empty after reset");

endmodule

// ===== dv/tb_utf8_to_utf16_converter.sv =====
module tb_utf8_to_utf16_converter;
  import u8u16_pkg::*;

  localparam int ClkPeriod     = 8;
  localparam int ResetCycles   = 7;
  localparam int RandomBytes   = 1800;
  localparam int SteadyBytes   = 1530;
  localparam int DrainInterval = 500;
  localparam int SettleCycles  = 16;
  localparam int TimeoutCycles = 400000;
  localparam int MaxPrinted    = 100;

  // how a directed row gets its expected words
  localparam int UsePredictor = -1;
  localparam int NoWord       = 0;
  localparam int OneWord      = 1;

  typedef struct packed {
    logic [UnitWidth-1:0] unit;
    logic                 last;
  } word_t;

  typedef struct {
    logic [ByteWidth-1:0] data;
    int                   mode;
    logic [UnitWidth-1:0] unit;
  } byte_row_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic [ByteWidth-1:0] in_byte;
  logic                 full;
  logic                 empty;
  logic                 pop;
  logic [UnitWidth-1:0] code_unit;
  logic                 last_unit;

  // decoder state mirrored by the predictor
  logic [2:0]         seq_left;
  logic [CpWidth-1:0] cp_accum;
  logic               skip_run;

  word_t expected_words[$];
  int    mismatch_count = 0;
  int    sent_count = 0;
  logic  steady = 1'b0;

  utf8_to_utf16_converter dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_byte   (in_byte),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // directed bytes: extremes, lone continuation, bad lead run, pairs, drop on zero
  byte_row_t directed_rows [26] = '{
    '{8'h00, NoWord,       16'h0000},
    '{8'h41, OneWord,      16'h0041},
    '{8'h7F, OneWord,      16'h007F},
    '{8'h80, OneWord,      16'h0000},
    '{8'hBF, OneWord,      16'h003F},
    '{8'hC3, NoWord,       16'h0000},
    '{8'hA9, UsePredictor, 16'h0000},
    '{8'hF0, NoWord,       16'h0000},
    '{8'h9F, NoWord,       16'h0000},
    '{8'h98, NoWord,       16'h0000},
    '{8'h80, UsePredictor, 16'h0000},
    '{8'hFD, NoWord,       16'h0000},
    '{8'hBF, NoWord,       16'h0000},
    '{8'hBF, NoWord,       16'h0000},
    '{8'hBF, NoWord,       16'h0000},
    '{8'hBF, NoWord,       16'h0000},
    '{8'hFF, UsePredictor, 16'h0000},
    '{8'hFE, NoWord,       16'h0000},
    '{8'hC0, NoWord,       16'h0000},
    '{8'hFF, NoWord,       16'h0000},
    '{8'h01, NoWord,       16'h0000},
    '{8'h7F, NoWord,       16'h0000},
    '{8'h80, NoWord,       16'h0000},
    '{8'hBF, OneWord,      16'h0000},
    '{8'hE2, NoWord,       16'h0000},
    '{8'h00, NoWord,       16'h0000}
  };

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MaxPrinted) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  // code point to one word or a surrogate pair
  function automatic int split_code_point(input logic [CpWidth-1:0] cp,
                                          output word_t w0, output word_t w1);
    logic [CpWidth-1:0] offset;
    offset = cp - SuppBase;
    w1 = '0;
    if (cp[CpWidth-1:UnitWidth] != '0) begin
      w0.unit = offset[UnitWidth+9:10] | HighSurr;
      w0.last = 1'b0;
      w1.unit = {LowPrefix, cp[9:0]};
      w1.last = 1'b1;
      return 2;
    end
    w0.unit = cp[UnitWidth-1:0];
    w0.last = 1'b1;
    return 1;
  endfunction

  // advance the decoder by one byte, return the words it yields
  function automatic int decode_byte(input logic [ByteWidth-1:0] b,
                                     output word_t w0, output word_t w1);
    logic [2:0]           ones;
    logic [ByteWidth-1:0] payload;
    logic [CpWidth-1:0]   cp;
    w0 = '0;
    w1 = '0;
    if (b == '0) begin
      seq_left = '0;
      cp_accum = '0;
      skip_run = 1'b0;
      return 0;
    end
    // following byte, taken without a form check
    if (seq_left != '0) begin
      if (!skip_run) cp_accum = {cp_accum[CpWidth-7:0], b[5:0]};
      seq_left = seq_left - 3'd1;
      if (seq_left != '0) return 0;
      cp = skip_run ? '0 : cp_accum;
      cp_accum = '0;
      skip_run = 1'b0;
      return split_code_point(cp, w0, w1);
    end
    // lead byte: leading ones down to bit 1
    ones = '0;
    payload = b;
    for (int i = ByteWidth - 1; i >= 1; i--) begin
      if (!b[i]) break;
      ones++;
      payload[i] = 1'b0;
    end
    if (ones == OnesBadLead) begin
      skip_run = 1'b1;
      cp_accum = '0;
      seq_left = BadRunLength;
      return 0;
    end
    if (ones <= OnesLone) begin
      cp_accum = '0;
      return split_code_point(CpWidth'(payload), w0, w1);
    end
    cp_accum = CpWidth'(payload);
    skip_run = 1'b0;
    seq_left = ones - 3'd1;
    return 0;
  endfunction

  // offer one byte, wait for acceptance, then queue what it should yield
  task automatic send_byte(input logic [ByteWidth-1:0] b, input int mode = UsePredictor,
                           input logic [UnitWidth-1:0] unit = '0);
    word_t w0, w1;
    int    n;
    if (!steady && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    push    <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (full);
    sent_count++;
    n = decode_byte(b, w0, w1);
    if (mode == UsePredictor) begin
      if (n >= 1) expected_words.push_back(w0);
      if (n == 2) expected_words.push_back(w1);
    end else if (mode == OneWord) begin
      expected_words.push_back('{unit: unit, last: 1'b1});
    end
  endtask

  task automatic send_lead_group(input int len, input int followers, input bit loose);
    logic [ByteWidth-1:0] lead;
    if (len == 1) begin
      lead = ByteWidth'($urandom_range(1, 127));
    end else begin
      lead = (8'hFF << (8 - len)) | (ByteWidth'($urandom) & (8'hFF >> (len + 1)));
    end
    send_byte(lead);
    repeat (followers) begin
      if (loose && $urandom_range(0, 9) == 0) send_byte(ByteWidth'($urandom_range(1, 255)));
      else send_byte(8'h80 | ByteWidth'($urandom_range(0, 63)));
    end
  endtask

  // mostly well-formed sequences, with bad leads, stray bytes and cut-off runs
  task automatic send_random_group();
    int kind, r, len;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    len = (r < 25) ? 1 : (r < 45) ? 2 : (r < 65) ? 3 : (r < 85) ? 4 : (r < 93) ? 5 : 6;
    if (kind < 60) begin
      send_lead_group(len, len - 1, 1'b1);
    end else if (kind < 68) begin
      send_byte(8'hFE | ByteWidth'($urandom_range(0, 1)));
      repeat (BadRunLength) send_byte(ByteWidth'($urandom_range(1, 255)));
    end else if (kind < 76) begin
      send_byte(8'h80 | ByteWidth'($urandom_range(0, 63)));
    end else if (kind < 84) begin
      send_byte(8'h00);
    end else if (kind < 92) begin
      len = $urandom_range(2, 6);
      send_lead_group(len, $urandom_range(0, len - 2), 1'b0);
      send_byte(8'h00);
    end else begin
      send_byte(ByteWidth'($urandom_range(0, 255)));
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  task automatic check_word(input logic [UnitWidth-1:0] unit, input logic last);
    word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h last %b", unit, last));
      return;
    end
    want = expected_words.pop_front();
    if (unit !== want.unit) begin
      report_mismatch($sformatf("code_unit %h, want %h", unit, want.unit));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last_unit %b, want %b on word %h", last, want.last, want.unit));
    end
  endtask

  // result side: take words, stall in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_word(code_unit, last_unit);
      if (rst) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // main sequence
  initial begin
    int next_drain;
    rst     <= 1'b1;
    push    <= 1'b0;
    in_byte <= '0;
    seq_left = '0;
    cp_accum = '0;
    skip_run = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].mode, directed_rows[i].unit);
    end

    next_drain = sent_count + DrainInterval;
    while (sent_count < $size(directed_rows) + RandomBytes) begin
      if (sent_count >= next_drain) begin
        wait_drained();
        next_drain += DrainInterval;
      end
      if (sent_count >= $size(directed_rows) + SteadyBytes) steady = 1'b1;
      send_random_group();
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
